// File: hw/rtl/mid_deq_pkg.sv
// ----------------------------------------------------------------------------
// mid_deq_pkg
// Shared types and codes for the middle-insert deque: item layouts, operation
// and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package mid_deq_pkg;

   localparam int COUNT_W = 6;
   localparam int VALUE_W = 32;

   // operation codes carried in the request opcode field
   localparam logic [2:0] OP_INSERT    = 3'd0;
   localparam logic [2:0] OP_POP_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_BACK  = 3'd2;
   localparam logic [2:0] OP_POP_MID   = 3'd3;
   localparam logic [2:0] OP_DUMP      = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]                opcode;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] value_res;
      logic                      last;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

   // what the whole chain does this cycle
   typedef enum logic [1:0] {
      CK_HOLD   = 2'd0,
      CK_INSERT = 2'd1,
      CK_REMOVE = 2'd2,
      CK_ROTATE = 2'd3
   } cell_kind_type;

   // control word seen by one cell
   typedef struct packed {
      cell_kind_type kind;
      logic          hit;   // cell sits at the operation position
      logic          past;  // cell sits beyond the operation position
      logic          tail;  // cell holds the back entry
   } cell_ctl_type;

endpackage

// File: hw/rtl/mid_deq_cell.sv
// ----------------------------------------------------------------------------
// mid_deq_cell
// One storage cell of the deque chain. Holds one entry and, each cycle, keeps
// it, loads the broadcast value, or takes its left or right neighbour's entry.
// ----------------------------------------------------------------------------
module mid_deq_cell
   import mid_deq_pkg::*;
(
   input  logic                      clock,
   input  cell_ctl_type              ctl,
   input  logic signed [VALUE_W-1:0] load_data,
   input  logic signed [VALUE_W-1:0] left_data,
   input  logic signed [VALUE_W-1:0] right_data,
   output logic signed [VALUE_W-1:0] data_out
);

   logic signed [VALUE_W-1:0] data_ff;
   logic signed [VALUE_W-1:0] data_in;

   // choose the next entry for this cell
   always_comb begin
      data_in = data_ff;
      unique case (ctl.kind)
         CK_HOLD: begin
            data_in = data_ff;
         end
         CK_INSERT: begin
            if (ctl.hit) begin
               data_in = load_data;
            end else if (ctl.past) begin
               data_in = left_data;
            end
         end
         CK_REMOVE: begin
            if (ctl.hit || ctl.past) begin
               data_in = right_data;
            end
         end
         CK_ROTATE: begin
            data_in = ctl.tail ? load_data : right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // hold the entry
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

// File: hw/rtl/middle_insert_deque_top.sv
// ----------------------------------------------------------------------------
// middle_insert_deque_top
// Bounded ordered list of signed values with insert at the middle and removal
// at front, back or middle, plus a front-to-back read-out.
// ----------------------------------------------------------------------------
// Entries live in a row of DEPTH cells that all shift in the same cycle, so the
// block accepts an insert or a removal every cycle while the result register
// drains. A read-out of n entries first takes the item, then the chain rotates
// one cell per cycle past the result register whenever that register is free,
// and after n steps it is back in its original order; no item is accepted
// until the last entry has gone into the result register. An empty read-out,
// a removal from an empty list and an insert into a full list give one result.
// The cells need no clearing after reset; only positions below the count are
// ever read. The count field carries the low 6 bits of the number of entries.
// ----------------------------------------------------------------------------
module middle_insert_deque_top
   import mid_deq_pkg::*;
#(
   parameter int DEPTH = 32
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DUMP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic                      out_free;
   logic                      req_take;
   logic [CW-1:0]             pos;
   logic                      full;
   logic                      empty;
   logic                      dump_last;
   cell_kind_type             kind;
   logic signed [VALUE_W-1:0] load_bus;
   logic signed [VALUE_W-1:0] sel_data;
   cell_ctl_type              cell_ctl  [DEPTH];
   logic signed [VALUE_W-1:0] cell_data [DEPTH];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_take  = req_valid && req_ready;
   assign full      = (cnt_ff == CW'(DEPTH));
   assign empty     = (cnt_ff == '0);
   assign dump_last = (idx_ff == cnt_ff - 1'b1);

   // position the operation works on
   always_comb begin
      priority case (req_data.opcode)
         OP_POP_FRONT: pos = '0;
         OP_POP_BACK:  pos = cnt_ff - 1'b1;
         default:      pos = cnt_ff >> 1;
      endcase
   end

   // broadcast value: new entry on insert, front entry while rotating
   assign load_bus = (state_ff == S_DUMP) ? cell_data[0] : req_data.value;

   // per-cell control and the entry at the operation position
   always_comb begin
      sel_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         cell_ctl[i].kind = kind;
         cell_ctl[i].hit  = (CW'(i) == pos);
         cell_ctl[i].past = (CW'(i) > pos);
         cell_ctl[i].tail = (CW'(i) == cnt_ff - 1'b1);
         if (cell_ctl[i].hit) begin
            sel_data = sel_data | cell_data[i];
         end
      end
   end

   // sequence operations and build the result item
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      kind         = CK_HOLD;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               priority case (req_data.opcode)
                  OP_INSERT: begin
                     rsp_valid_in          = 1'b1;
                     rsp_data_in.value_res = '0;
                     rsp_data_in.last      = 1'b1;
                     if (full) begin
                        rsp_data_in.status = ST_FULL;
                        rsp_data_in.count  = COUNT_W'(cnt_ff);
                     end else begin
                        kind               = CK_INSERT;
                        cnt_in             = cnt_ff + 1'b1;
                        rsp_data_in.status = ST_OK;
                        rsp_data_in.count  = COUNT_W'(cnt_ff + 1'b1);
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK, OP_POP_MID: begin
                     rsp_valid_in     = 1'b1;
                     rsp_data_in.last = 1'b1;
                     if (empty) begin
                        rsp_data_in.status    = ST_EMPTY;
                        rsp_data_in.value_res = '0;
                        rsp_data_in.count     = '0;
                     end else begin
                        kind                  = CK_REMOVE;
                        cnt_in                = cnt_ff - 1'b1;
                        rsp_data_in.status    = ST_OK;
                        rsp_data_in.value_res = sel_data;
                        rsp_data_in.count     = COUNT_W'(cnt_ff - 1'b1);
                     end
                  end
                  OP_DUMP: begin
                     if (empty) begin
                        rsp_valid_in          = 1'b1;
                        rsp_data_in.status    = ST_EMPTY;
                        rsp_data_in.value_res = '0;
                        rsp_data_in.last      = 1'b1;
                        rsp_data_in.count     = '0;
                     end else begin
                        state_in = S_DUMP;
                        idx_in   = '0;
                     end
                  end
                  default: begin
                     // undefined opcode: drop the item
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               kind                  = CK_ROTATE;
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = ST_OK;
               rsp_data_in.value_res = cell_data[0];
               rsp_data_in.last      = dump_last;
               rsp_data_in.count     = COUNT_W'(cnt_ff);
               idx_in                = idx_ff + 1'b1;
               if (dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the cell chain
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left_w;
      logic signed [VALUE_W-1:0] right_w;
      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_inner_l
         assign left_w = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_inner_r
         assign right_w = cell_data[g+1];
      end
      mid_deq_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[g]),
         .load_data  (load_bus),
         .left_data  (left_w),
         .right_data (right_w),
         .data_out   (cell_data[g])
      );
   end

endmodule

// File: hw/rtl/mid_deq_checker.sv
// ----------------------------------------------------------------------------
// mid_deq_checker
// Port-level checks on the deque: result handshake, back-pressure and the
// consistency of status, value and count in each result item.
// ----------------------------------------------------------------------------
module mid_deq_checker
   import mid_deq_pkg::*;
#(
   parameter int DEPTH = 32
)
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result item stays offered and unchanged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
   else $error("result item dropped or changed while stalled");

   // no new item is taken while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
   else $error("item accepted while result register blocked");

   // an empty result is a single item with nothing held
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |->
         rsp_data.last && rsp_data.count == '0 && rsp_data.value_res == '0)
   else $error("malformed empty result");

   // a full result reports the capacity and no value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |->
         rsp_data.last && rsp_data.value_res == '0 &&
         rsp_data.count == COUNT_W'(DEPTH))
   else $error("malformed full result");

   // status stays within its defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == ST_OK || rsp_data.status == ST_EMPTY ||
                    rsp_data.status == ST_FULL)
   else $error("undefined status code");

endmodule

bind middle_insert_deque_top mid_deq_checker #(.DEPTH(DEPTH)) u_mid_deq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: tb/sv/middle_insert_deque_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// middle_insert_deque_checker
// Watches both channels of the middle-insert deque, keeps its own copy of the
// list, predicts the results of every accepted item and compares each
// accepted result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module middle_insert_deque_checker
   import mid_deq_pkg::*;
#(
   parameter int DEPTH = 32
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      results_pending
);

   // list contents, front first
   logic signed [VALUE_W-1:0] list_entries[$];
   // predicted results, oldest first
   rsp_type                   expected_results[$];

   // queue one prediction; the count is taken after the operation
   function automatic void push_expected(input logic [1:0] status,
                                         input logic signed [VALUE_W-1:0] val,
                                         input logic last);
      rsp_type r;
      int      n;
      n           = list_entries.size();
      r.status    = status;
      r.value_res = val;
      r.last      = last;
      r.count     = n[COUNT_W-1:0];
      expected_results.push_back(r);
   endfunction

   // apply one accepted item to the list and predict its results
   function automatic void predict_list_op(input req_type item);
      int                        pos;
      int                        n;
      logic signed [VALUE_W-1:0] taken;
      n = list_entries.size();
      case (item.opcode)
         OP_INSERT: begin
            if (n >= DEPTH) begin
               push_expected(ST_FULL, '0, 1'b1);
            end else begin
               pos = n / 2;
               list_entries.insert(pos, item.value);
               push_expected(ST_OK, '0, 1'b1);
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_POP_MID: begin
            if (n == 0) begin
               push_expected(ST_EMPTY, '0, 1'b1);
            end else begin
               if (item.opcode == OP_POP_FRONT)
                  pos = 0;
               else if (item.opcode == OP_POP_BACK)
                  pos = n - 1;
               else
                  pos = n / 2;
               taken = list_entries[pos];
               list_entries.delete(pos);
               push_expected(ST_OK, taken, 1'b1);
            end
         end
         OP_DUMP: begin
            if (n == 0) begin
               push_expected(ST_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++)
                  push_expected(ST_OK, list_entries[i], i == n - 1);
            end
         end
         default: begin
            // undefined codes leave the list alone and give nothing
         end
      endcase
   endfunction

   // compare one accepted result with the oldest prediction
   function automatic void compare_result(input rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         $error("unexpected result: status %0d value_res %0d last %0d count %0d",
                got.status, got.value_res, got.last, got.count);
         fail_count++;
      end else begin
         want = expected_results.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
         end
         if (got.value_res !== want.value_res) begin
            $error("value_res: expected %0d, actual %0d", want.value_res, got.value_res);
            fail_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fail_count++;
         end
         if (got.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, got.count);
            fail_count++;
         end
      end
   endfunction

   // predict before comparing, so a result in the accepting cycle still finds its item
   always @(posedge clock) begin
      if (reset) begin
         fail_count      = 0;
         results_pending = 0;
      end else begin
         if (req_valid && req_ready)
            predict_list_op(req_data);
         if (rsp_valid && rsp_ready)
            compare_result(rsp_data);
         results_pending = expected_results.size();
      end
   end

endmodule

// File: tb/sv/tb_middle_insert_deque_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_middle_insert_deque_top
// Drives directed and random list operations into the middle-insert deque
// under varying idle patterns and one long result back-pressure, and gives
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_middle_insert_deque_top;
   import mid_deq_pkg::*;

   localparam int         DEPTH          = 32;
   localparam int         ITEMS_PER_PASS = 120;
   localparam int         HOLD_CYCLES    = 400;
   localparam int         DRAIN_CYCLES   = 60;
   localparam int         CYCLE_LIMIT    = 400000;
   localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
   localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int results_pending;
   int items_sent    = 0;
   int cycle_count   = 0;
   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   bit hold_trigger  = 1'b0;
   bit hold_started  = 1'b0;
   int hold_left     = 0;

   middle_insert_deque_top #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   middle_insert_deque_checker #(.DEPTH(DEPTH)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   always #5 clock = ~clock;

   // count cycles for the run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // stop a hung run
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("middle_insert_deque_top test failed");
      $finish;
   end

   // result side: random stalls, plus one long hold-off when asked
   always @(posedge clock) begin
      if (hold_trigger && !hold_started) begin
         hold_started = 1'b1;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // offer one item and hold it until accepted
   task automatic send_item(input logic [2:0] op, input logic signed [VALUE_W-1:0] val);
      req_type item;
      item.opcode = op;
      item.value  = val;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (op <= OP_DUMP)
         items_sent++;
   endtask

   // mostly random words, sometimes the extremes
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_pop();
      case ($urandom_range(2))
         0:       return OP_POP_FRONT;
         1:       return OP_POP_BACK;
         default: return OP_POP_MID;
      endcase
   endfunction

   // weighted towards inserts so the list grows
   function automatic logic [2:0] pick_op();
      int r;
      r = $urandom_range(99);
      if (r < 48)
         return OP_INSERT;
      else if (r < 85)
         return pick_pop();
      else if (r < 95)
         return OP_DUMP;
      else
         return 3'($urandom_range(OP_UNDEF_LAST, OP_UNDEF_FIRST));
   endfunction

   // fill past full, read out, then empty past empty
   task automatic fill_and_drain();
      repeat (DEPTH + 3)
         send_item(OP_INSERT, pick_value());
      send_item(OP_DUMP, pick_value());
      repeat (DEPTH + 2)
         send_item(pick_pop(), pick_value());
   endtask

   task automatic run_random(input int quota);
      int target;
      target = items_sent + quota;
      while (items_sent < target) begin
         if ($urandom_range(99) < 12) begin
            fill_and_drain();
         end else begin
            repeat ($urandom_range(16, 1))
               send_item(pick_op(), pick_value());
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // pass one: sender rarely idle, receiver often stalled
      req_idle_pct = 7;
      rsp_idle_pct = 61;

      // directed: empty cases, undefined codes, extremes, each operation
      send_item(OP_POP_FRONT, 32'sh1234_5678);
      send_item(OP_POP_BACK, '0);
      send_item(OP_POP_MID, '1);
      send_item(OP_DUMP, '0);
      send_item(OP_UNDEF_FIRST, 32'sh7FFF_FFFF);
      send_item(OP_UNDEF_LAST, 32'sh8000_0000);
      send_item(OP_INSERT, 32'sh7FFF_FFFF);
      send_item(OP_INSERT, 32'sh8000_0000);
      send_item(OP_INSERT, '0);
      send_item(OP_INSERT, '1);
      send_item(OP_INSERT, 32'sh5555_5555);
      send_item(OP_INSERT, 32'shAAAA_AAAA);
      send_item(OP_DUMP, '0);
      send_item(OP_POP_MID, '0);
      send_item(OP_POP_FRONT, '0);
      send_item(OP_POP_BACK, '0);
      send_item(OP_DUMP, '0);
      send_item(OP_POP_MID, '0);
      send_item(OP_POP_MID, '0);
      send_item(OP_POP_MID, '0);
      send_item(OP_DUMP, '0);

      run_random(ITEMS_PER_PASS);

      // pass two: roles swapped
      req_idle_pct = 61;
      rsp_idle_pct = 7;
      run_random(ITEMS_PER_PASS);

      // pass three: no idling; hold results off while items keep coming
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_trigger = 1'b1;
      repeat (40)
         send_item(pick_op(), pick_value());
      run_random(ITEMS_PER_PASS);

      req_valid <= 1'b0;
      while (results_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && results_pending == 0) begin
         $display("middle_insert_deque_top test passed");
      end else begin
         $display("middle_insert_deque_top test failed");
      end
      $finish;
   end

endmodule
